// ===== hdl/fthm_pkg.sv =====
package fthm_pkg;

  localparam int unsigned TsW      = 40;
  localparam int unsigned NomW     = 20;
  localparam int unsigned CntW     = 32;
  localparam int unsigned PavgW    = 56;
  localparam int unsigned OavgW    = 58;
  localparam int unsigned DivInW   = 56;
  localparam int unsigned DivOutW  = 54;

  localparam logic [NomW-1:0] NOM_RESET = 20'd33333;

  // event codes
  localparam logic [1:0] OP_FRAME    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT  = 2'd1;
  localparam logic [1:0] OP_UNPAIRED = 2'd2;

  typedef struct packed {
    logic [1:0]     opcode;
    logic [TsW-1:0] depth_ts_us;
    logic [TsW-1:0] color_ts_us;
    logic           dev_attached;
  } evt_t;

  typedef struct packed {
    logic [CntW-1:0]        frame_count;
    logic [CntW-1:0]        dropout_count;
    logic [CntW-1:0]        unpaired_count;
    logic [CntW-1:0]        period_avg_q4;
    logic [CntW-1:0]        max_gap_us;
    logic signed [CntW-1:0] offset_avg_q4;
    logic                   present_flag;
  } stat_t;

  // health figures held between events
  typedef struct packed {
    logic [CntW-1:0]         frames_seen;
    logic [CntW-1:0]         dropouts_seen;
    logic [CntW-1:0]         unpaired_seen;
    logic [PavgW-1:0]        period_avg;
    logic [CntW-1:0]         max_gap;
    logic signed [OavgW-1:0] offset_avg;
    logic                    present_reg;
  } health_t;

endpackage

// ===== hdl/fthm_div5.sv =====
module fthm_div5 (
  input  logic [fthm_pkg::DivInW-1:0]  dividend,
  output logic [fthm_pkg::DivOutW-1:0] quotient
);

  // 2^28 = 1 mod 5, so m = hi*(2^28-1) + (hi+lo) and (2^28-1)/5 is exact.
  localparam logic [25:0] HiRecip = 26'h3333333;
  // floor(x/5) = (x * 0xCCCCCCCD) >> 34 for any x below 2^32
  localparam logic [31:0] LoRecip = 32'hCCCCCCCD;

  logic [27:0] hi;
  logic [27:0] lo;
  logic [28:0] fold;
  logic [53:0] hi_part;
  logic [60:0] lo_prod;
  logic [26:0] lo_part;

  assign hi      = dividend[55:28];
  assign lo      = dividend[27:0];
  assign fold    = {1'b0, hi} + {1'b0, lo};
  assign hi_part = {26'd0, hi} * {28'd0, HiRecip};
  assign lo_prod = {32'd0, fold} * {29'd0, LoRecip};
  assign lo_part = lo_prod[60:34];

  assign quotient = hi_part + {27'd0, lo_part};

endmodule

// ===== hdl/fthm_core.sv =====
module fthm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  fthm_pkg::evt_t                item,
  input  logic                          cfg_we,
  input  logic [fthm_pkg::NomW-1:0]     cfg_value,
  output fthm_pkg::health_t             health
);

  logic [fthm_pkg::NomW-1:0] nominal;
  logic [fthm_pkg::TsW-1:0]  prev_depth_ts;
  logic                      prev_valid;
  fthm_pkg::health_t         health_next;
  logic [fthm_pkg::TsW-1:0]  prev_depth_ts_next;
  logic                      prev_valid_next;

  // offset path
  logic signed [40:0]        diff;
  logic [56:0]               o_target;
  logic [58:0]               o_err;
  logic [58:0]               o_mag;
  logic [fthm_pkg::DivOutW-1:0] o_q;

  // period path
  logic [fthm_pkg::TsW-1:0]  gap;
  logic [55:0]               p_target;
  logic [56:0]               p_err;
  logic [56:0]               p_mag;
  logic [fthm_pkg::DivOutW-1:0] p_q;
  logic [31:0]               gap32;
  logic [40:0]               gap_x2;
  logic [21:0]               nom_x3;

  function automatic logic [fthm_pkg::CntW-1:0] sat_inc(input logic [fthm_pkg::CntW-1:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  assign diff     = $signed({1'b0, item.color_ts_us}) - $signed({1'b0, item.depth_ts_us});
  assign o_target = {diff, 16'd0};
  assign o_err    = {{2{o_target[56]}}, o_target} - {health.offset_avg[57], health.offset_avg};
  assign o_mag    = o_err[58] ? (59'd0 - o_err) : o_err;

  fthm_div5 u_div_offset (
    .dividend (o_mag[57:2]),
    .quotient (o_q)
  );

  assign gap      = (item.depth_ts_us >= prev_depth_ts) ? item.depth_ts_us - prev_depth_ts : '0;
  assign p_target = {gap, 16'd0};
  assign p_err    = {1'b0, p_target} - {1'b0, health.period_avg};
  assign p_mag    = p_err[56] ? (57'd0 - p_err) : p_err;

  fthm_div5 u_div_period (
    .dividend ({1'b0, p_mag[55:1]}),
    .quotient (p_q)
  );

  assign gap32  = (gap[39:32] != 8'd0) ? 32'hFFFF_FFFF : gap[31:0];
  assign gap_x2 = {gap, 1'b0};
  assign nom_x3 = {1'b0, nominal, 1'b0} + {2'd0, nominal};

  always_comb begin
    health_next        = health;
    prev_depth_ts_next = prev_depth_ts;
    prev_valid_next    = prev_valid;
    health_next.present_reg = item.dev_attached;
    if (item.dev_attached) begin
      unique case (item.opcode)
        fthm_pkg::OP_FRAME: begin
          health_next.offset_avg  = o_err[58] ? health.offset_avg - {4'd0, o_q}
                                              : health.offset_avg + {4'd0, o_q};
          health_next.frames_seen = sat_inc(health.frames_seen);
          if (prev_valid) begin
            health_next.period_avg = p_err[56] ? health.period_avg - {2'd0, p_q}
                                               : health.period_avg + {2'd0, p_q};
            if (gap32 > health.max_gap) begin
              health_next.max_gap = gap32;
            end
            if (gap_x2 > {19'd0, nom_x3}) begin
              health_next.dropouts_seen = sat_inc(health.dropouts_seen);
            end
          end else begin
            health_next.period_avg = {20'd0, nominal, 16'd0};
          end
          prev_depth_ts_next = item.depth_ts_us;
          prev_valid_next    = 1'b1;
        end
        fthm_pkg::OP_TIMEOUT: begin
          health_next.dropouts_seen = sat_inc(health.dropouts_seen);
        end
        fthm_pkg::OP_UNPAIRED: begin
          health_next.unpaired_seen = sat_inc(health.unpaired_seen);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal       <= fthm_pkg::NOM_RESET;
      prev_depth_ts <= '0;
      prev_valid    <= 1'b0;
      health        <= '{frames_seen: '0, dropouts_seen: '0, unpaired_seen: '0,
                         period_avg: '0, max_gap: '0, offset_avg: '0, present_reg: 1'b1};
    end else begin
      if (cfg_we) begin
        nominal <= cfg_value;
      end
      if (take) begin
        health        <= health_next;
        prev_depth_ts <= prev_depth_ts_next;
        prev_valid    <= prev_valid_next;
      end
    end
  end

endmodule

// ===== hdl/fthm_report.sv =====
module fthm_report (
  input  fthm_pkg::health_t health,
  output fthm_pkg::stat_t   report
);

  logic [57:0] off_adj;
  logic [45:0] off_q4;
  logic        off_fits;

  // divide by 4096 toward zero: bias negatives before the shift
  assign off_adj  = health.offset_avg + (health.offset_avg[57] ? 58'd4095 : 58'd0);
  assign off_q4   = off_adj[57:12];
  assign off_fits = (off_q4[45:31] == '0) || (off_q4[45:31] == '1);

  always_comb begin
    report.frame_count    = health.frames_seen;
    report.dropout_count  = health.dropouts_seen;
    report.unpaired_count = health.unpaired_seen;
    report.period_avg_q4  = (health.period_avg[55:44] != 12'd0) ? 32'hFFFF_FFFF
                                                                : health.period_avg[43:12];
    report.max_gap_us     = health.max_gap;
    if (off_fits) begin
      report.offset_avg_q4 = off_q4[31:0];
    end else if (off_q4[45]) begin
      report.offset_avg_q4 = 32'h8000_0000;
    end else begin
      report.offset_avg_q4 = 32'h7FFF_FFFF;
    end
    report.present_flag   = health.present_reg;
  end

endmodule

// ===== hdl/frame_timing_health_monitor.sv =====
// Channel | Direction | Handshake                  | Payload
// evt     | in        | evt_valid / evt_stall      | evt_data (fthm_pkg::evt_t)
// stat    | out       | stat_valid / stat_stall    | stat_data (fthm_pkg::stat_t)
// cfg     | in        | cfg_valid / cfg_ready      | cfg_data, nominal period in us
//
// One event per cycle while results do not stall; an event is registered at input, then in the health registers.
// The pace is set by the combinational update of the health registers (two divide-by-5 units).
// rst is synchronous: figures clear, presence reads one, nominal period returns to 33333 us.
// A stalled result holds the health registers; one event waits in the input register.
// cfg_ready is always high; write the nominal period only while no event is in flight.
module frame_timing_health_monitor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      evt_valid,
  output logic                      evt_stall,
  input  fthm_pkg::evt_t            evt_data,
  output logic                      stat_valid,
  input  logic                      stat_stall,
  output fthm_pkg::stat_t           stat_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fthm_pkg::NomW-1:0] cfg_data
);

  // input register
  logic              evt_held;
  fthm_pkg::evt_t    evt_reg;
  logic              take;
  logic              evt_xfer;
  fthm_pkg::health_t health;

  // Advance the held event once the result slot is empty or draining this cycle.
  assign take      = evt_held && (!stat_valid || !stat_stall);
  assign evt_stall = evt_held && !take;
  assign evt_xfer  = evt_valid && !evt_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_held   <= 1'b0;
      stat_valid <= 1'b0;
    end else begin
      if (evt_xfer) begin
        evt_held <= 1'b1;
      end else if (take) begin
        evt_held <= 1'b0;
      end
      // hold the result while the consumer stalls
      if (take) begin
        stat_valid <= 1'b1;
      end else if (!stat_stall) begin
        stat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_xfer) begin
      evt_reg <= evt_data;
    end
  end

  // Health registers double as the result register: they change only on take or reset.
  fthm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (evt_reg),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .health    (health)
  );

  fthm_report u_report (
    .health (health),
    .report (stat_data)
  );

endmodule

// ===== hdl/fthm_checker.sv =====
module fthm_checker (
  input logic            clk,
  input logic            rst,
  input logic            evt_valid,
  input logic            evt_stall,
  input fthm_pkg::stat_t stat_data,
  input logic            stat_valid,
  input logic            stat_stall
);

  a_stat_hold: assert property (@(posedge clk) disable iff (rst)
    stat_valid && stat_stall |=> stat_valid && $stable(stat_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stat_valid && !evt_stall)
    else $error("pipeline not empty after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stat_valid |-> !evt_stall)
    else $error("input stalled with empty result slot");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_stall |=> ##1 stat_valid)
    else $error("transferred event produced no result");

endmodule

bind frame_timing_health_monitor fthm_checker u_fthm_checker (
  .clk        (clk),
  .rst        (rst),
  .evt_valid  (evt_valid),
  .evt_stall  (evt_stall),
  .stat_data  (stat_data),
  .stat_valid (stat_valid),
  .stat_stall (stat_stall)
);

// ===== bench/fthm_checker.sv =====
`timescale 1ns / 1ps

module fthm_bench_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      evt_valid,
  input  logic                      evt_stall,
  input  fthm_pkg::evt_t            evt_data,
  input  logic                      stat_valid,
  input  logic                      stat_stall,
  input  fthm_pkg::stat_t           stat_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [fthm_pkg::NomW-1:0] cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam longint U32_TOP = 64'h0000_0000_FFFF_FFFF;
  localparam longint I32_TOP = 64'sd2147483647;
  localparam longint I32_BOT = -64'sd2147483648;

  // shadow copy of the health figures
  logic [fthm_pkg::NomW-1:0] nominal_us;
  logic [fthm_pkg::TsW-1:0]  last_depth_ts;
  logic                      have_last;
  longint                    period_fx;
  longint                    offset_fx;
  logic [fthm_pkg::CntW-1:0] max_gap_q;
  logic [fthm_pkg::CntW-1:0] frames_q;
  logic [fthm_pkg::CntW-1:0] dropouts_q;
  logic [fthm_pkg::CntW-1:0] unpaired_q;
  logic                      present_q;

  fthm_pkg::stat_t expected_stats[$];
  fthm_pkg::stat_t want_stat;
  fthm_pkg::stat_t next_stat;
  int              fail_total = 0;

  assign errors = fail_total;

  function automatic logic [fthm_pkg::CntW-1:0] sat_inc(input logic [fthm_pkg::CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic update_health(input fthm_pkg::evt_t e, output fthm_pkg::stat_t s);
    longint diff;
    longint gap;
    longint gap_clip;
    longint p16;
    longint o16;
    if (!e.dev_attached) begin
      present_q = 1'b0;
    end else begin
      present_q = 1'b1;
      case (e.opcode)
        fthm_pkg::OP_FRAME: begin
          diff = longint'({24'd0, e.color_ts_us}) - longint'({24'd0, e.depth_ts_us});
          offset_fx = offset_fx + (diff * 65536 - offset_fx) / 20;
          frames_q = sat_inc(frames_q);
          if (have_last) begin
            gap = (e.depth_ts_us >= last_depth_ts) ?
                  longint'({24'd0, e.depth_ts_us - last_depth_ts}) : 0;
            period_fx = period_fx + (gap * 65536 - period_fx) / 10;
            gap_clip = (gap > U32_TOP) ? U32_TOP : gap;
            if (gap_clip > longint'({32'd0, max_gap_q})) max_gap_q = 32'(gap_clip);
            if (2 * gap > 3 * longint'({44'd0, nominal_us})) begin
              dropouts_q = sat_inc(dropouts_q);
            end
          end else begin
            period_fx = longint'({44'd0, nominal_us}) * 65536;
          end
          last_depth_ts = e.depth_ts_us;
          have_last = 1'b1;
        end
        fthm_pkg::OP_TIMEOUT:  dropouts_q = sat_inc(dropouts_q);
        fthm_pkg::OP_UNPAIRED: unpaired_q = sat_inc(unpaired_q);
        default: ;
      endcase
    end
    p16 = period_fx >>> 12;
    if (p16 > U32_TOP) p16 = U32_TOP;
    o16 = offset_fx / 4096;
    if (o16 > I32_TOP) o16 = I32_TOP;
    if (o16 < I32_BOT) o16 = I32_BOT;
    s.frame_count    = frames_q;
    s.dropout_count  = dropouts_q;
    s.unpaired_count = unpaired_q;
    s.period_avg_q4  = 32'(p16);
    s.max_gap_us     = max_gap_q;
    s.offset_avg_q4  = 32'(o16);
    s.present_flag   = present_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      nominal_us    = fthm_pkg::NOM_RESET;
      last_depth_ts = '0;
      have_last     = 1'b0;
      period_fx     = 0;
      offset_fx     = 0;
      max_gap_q     = '0;
      frames_q      = '0;
      dropouts_q    = '0;
      unpaired_q    = '0;
      present_q     = 1'b1;
      expected_stats.delete();
    end else begin
      if (cfg_valid && cfg_ready) nominal_us = cfg_data;
      // retire the result before queuing a new one from the same edge
      if (stat_valid && !stat_stall) begin
        if (expected_stats.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_total++;
        end else begin
          want_stat = expected_stats[0];
          expected_stats.delete(0);
          check_field("frame_count", want_stat.frame_count, stat_data.frame_count);
          check_field("dropout_count", want_stat.dropout_count, stat_data.dropout_count);
          check_field("unpaired_count", want_stat.unpaired_count, stat_data.unpaired_count);
          check_field("period_avg_q4", want_stat.period_avg_q4, stat_data.period_avg_q4);
          check_field("max_gap_us", want_stat.max_gap_us, stat_data.max_gap_us);
          check_field("offset_avg_q4", want_stat.offset_avg_q4, stat_data.offset_avg_q4);
          check_field("present_flag", {31'd0, want_stat.present_flag},
                      {31'd0, stat_data.present_flag});
        end
      end
      if (evt_valid && !evt_stall) begin
        update_health(evt_data, next_stat);
        expected_stats.insert(expected_stats.size(), next_stat);
      end
    end
    pending = expected_stats.size();
  end

endmodule

// ===== bench/frame_timing_health_monitor_tb.sv =====
`timescale 1ns / 1ps

module frame_timing_health_monitor_tb;

  // opcode the block must ignore apart from presence
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ITEMS_PER_CHUNK = 43;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      evt_valid  = 1'b0;
  logic                      evt_stall;
  fthm_pkg::evt_t            evt_data   = '0;
  logic                      stat_valid;
  logic                      stat_stall = 1'b0;
  fthm_pkg::stat_t           stat_data;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [fthm_pkg::NomW-1:0] cfg_data   = '0;

  int fail_count;
  int in_flight;

  // idle odds, in percent per cycle, for the sender and the receiver
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // nominal period as last written, and the running depth timestamp of the
  // well-formed stream
  logic [fthm_pkg::NomW-1:0] cur_nominal = fthm_pkg::NOM_RESET;
  logic [fthm_pkg::TsW-1:0]  stream_ts   = '0;

  always #2 clk = ~clk;

  // Drive the receiver stall once per cycle at the falling edge.
  always @(negedge clk) stat_stall <= ($urandom_range(99) < stall_pct);

  frame_timing_health_monitor dut (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt_data   (evt_data),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .stat_data  (stat_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  fthm_bench_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt_data   (evt_data),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .stat_data  (stat_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (fail_count),
    .pending    (in_flight)
  );

  function automatic fthm_pkg::evt_t frame_evt(input logic [fthm_pkg::TsW-1:0] depth,
                                               input logic [fthm_pkg::TsW-1:0] color);
    fthm_pkg::evt_t e;
    e.opcode       = fthm_pkg::OP_FRAME;
    e.depth_ts_us  = depth;
    e.color_ts_us  = color;
    e.dev_attached = 1'b1;
    return e;
  endfunction

  function automatic fthm_pkg::evt_t plain_evt(input logic [1:0] op, input logic present);
    fthm_pkg::evt_t e;
    e.opcode       = op;
    e.depth_ts_us  = '0;
    e.color_ts_us  = '0;
    e.dev_attached = present;
    return e;
  endfunction

  // Present one event and hold it until the block takes the transfer. Entered
  // and left at a falling edge. Valid is lowered only when an idle gap follows,
  // so a back-to-back event keeps valid high with no second assignment.
  task automatic send_event(input fthm_pkg::evt_t e);
    int gap;
    evt_data  <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_stall);
    @(negedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back, then
  // let the pipeline settle before returning.
  task automatic drain;
    evt_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the nominal period; call only while drained.
  task automatic write_nominal(input logic [fthm_pkg::NomW-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_nominal = value;
  endtask

  // Build one random event. Most are paired frames that follow the nominal
  // period with some jitter, a share of them long enough to count as a
  // dropout; the rest are timeouts, unpaired framesets, absent-device events
  // and fully random noise that breaks the timestamp sequence.
  task automatic send_random_event;
    fthm_pkg::evt_t e;
    int             pick;
    int             skew;
    longint         gap;
    logic [63:0]    noise_d;
    logic [63:0]    noise_c;
    pick = $urandom_range(99);
    if (pick < 80) begin
      gap       = (longint'({44'd0, cur_nominal}) * $urandom_range(6, 16)) / 8
                  + $urandom_range(0, 3);
      stream_ts = stream_ts + 40'(gap);
      skew      = int'($urandom_range(0, 4000)) - 2000;
      e         = frame_evt(stream_ts, stream_ts + 40'(skew));
    end else if (pick < 86) begin
      e = plain_evt(fthm_pkg::OP_TIMEOUT, 1'b1);
    end else if (pick < 91) begin
      e = plain_evt(fthm_pkg::OP_UNPAIRED, 1'b1);
    end else if (pick < 94) begin
      e = frame_evt(stream_ts + 40'(cur_nominal), stream_ts);
      e.opcode       = 2'($urandom_range(3));
      e.dev_attached = 1'b0;
    end else begin
      noise_d        = {$urandom, $urandom};
      noise_c        = {$urandom, $urandom};
      e.opcode       = 2'($urandom_range(3));
      e.depth_ts_us  = noise_d[fthm_pkg::TsW-1:0];
      e.color_ts_us  = noise_c[fthm_pkg::TsW-1:0];
      e.dev_attached = 1'($urandom_range(1));
    end
    send_event(e);
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("frame_timing_health_monitor test failed");
    $finish;
  end

  initial begin
    logic [fthm_pkg::NomW-1:0] nominal_plan [6];
    int                        idle_plan_send  [4];
    int                        idle_plan_stall [4];
    fthm_pkg::evt_t            e;

    nominal_plan    = '{20'd1, 20'd1000000, 20'hFFFFF, fthm_pkg::NOM_RESET, 20'd0, 20'd0};
    nominal_plan[5] = 20'($urandom_range(2, 999999));
    idle_plan_send  = '{0, 65, 0, 37};
    idle_plan_stall = '{0, 0, 65, 37};

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset nominal period of 33333 us.
    // First frame seeds the period average with the nominal period.
    send_event(frame_evt(40'd1000, 40'd1000));
    send_event(frame_evt(40'd34333, 40'd34338));
    // Gap just under and just over the dropout threshold (1.5 x nominal).
    send_event(frame_evt(40'd84332, 40'd84325));
    send_event(frame_evt(40'd134332, 40'd134332));
    // Depth timestamp going backwards counts as a zero gap.
    send_event(frame_evt(40'd10, 40'd10));
    send_event(plain_evt(fthm_pkg::OP_TIMEOUT, 1'b1));
    send_event(plain_evt(fthm_pkg::OP_UNPAIRED, 1'b1));
    send_event(plain_evt(OP_UNUSED, 1'b1));
    // Device absent: only the presence flag moves, whatever the opcode.
    e = frame_evt(40'd50000, 40'd50000);
    e.dev_attached = 1'b0;
    send_event(e);
    send_event(plain_evt(fthm_pkg::OP_TIMEOUT, 1'b0));
    send_event(frame_evt(40'd20, 40'd25));
    // Extreme timestamps: gap wider than 32 bits, offsets at both ends,
    // pushing both averages into output saturation.
    send_event(frame_evt('1, '0));
    send_event(frame_evt('0, '1));
    send_event(frame_evt('0, '1));
    send_event(frame_evt('1, '0));
    drain();

    // Zero nominal period: any nonzero gap is a dropout.
    write_nominal(20'd0);
    send_event(frame_evt(40'd0, 40'd0));
    send_event(frame_evt(40'd1, 40'd1));
    drain();

    // Nominal of one: a gap of one passes, a gap of two is a dropout.
    write_nominal(20'd1);
    send_event(frame_evt(40'd2, 40'd2));
    send_event(frame_evt(40'd4, 40'd4));
    drain();
    stream_ts = 40'd4;

    // Random part: every nominal setting under every idle pattern. Drain
    // before each register write; this also pauses the sender until every
    // expected result has come.
    foreach (nominal_plan[n]) begin
      send_idle_pct = 0;
      stall_pct     = 0;
      drain();
      write_nominal(nominal_plan[n]);
      foreach (idle_plan_send[m]) begin
        send_idle_pct = idle_plan_send[m];
        stall_pct     = idle_plan_stall[m];
        repeat (ITEMS_PER_CHUNK) send_random_event();
      end
    end

    // Let everything come back, then watch for stray results.
    drain();
    stall_pct = 0;
    repeat (16) @(negedge clk);

    if (fail_count == 0 && in_flight == 0) begin
      $display("frame_timing_health_monitor test passed");
    end else begin
      $display("frame_timing_health_monitor test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fthm_pkg.sv
hdl/fthm_div5.sv
hdl/fthm_core.sv
hdl/fthm_report.sv
hdl/frame_timing_health_monitor.sv
hdl/fthm_checker.sv
bench/fthm_checker.sv
bench/frame_timing_health_monitor_tb.sv
